// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the coefficient engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mce_pkg.sv
// Shared constants, types and helper functions of the multinomial coefficient engine.
package mce_pkg;

    localparam int MAX_ROW     = 63;
    localparam int STORE_DEPTH = (MAX_ROW + 1) * (MAX_ROW + 2) / 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FIELD_W     = 7;
    localparam int SUM_W       = 8;
    localparam int COEF_W      = 64;
    localparam int HALF_W      = COEF_W / 2;
    localparam int ACC_W       = 2 * COEF_W;
    localparam int IN_DATA_W   = ((3 * FIELD_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    localparam logic [SUM_W-1:0] SUM_CAP = '1;

    localparam logic OP_BINOMIAL    = 1'b0;
    localparam logic OP_MULTINOMIAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_BCHK,
        ST_BHEAD,
        ST_BNEXT,
        ST_BRD,
        ST_BWR,
        ST_BTAIL,
        ST_READ,
        ST_RWAIT,
        ST_MUL,
        ST_MDONE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic bin_fixed;
        logic set_nk_bin;
        logic list_first;
        logic list_range;
        logic list_skip;
        logic set_nk_list;
        logic row_init;
        logic row_head;
        logic row_rd;
        logic row_wr;
        logic row_tail;
        logic tbl_rd;
        logic bin_capture;
        logic mul_start;
        logic mul_step;
        logic mul_done;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic op_multi;
        logic last;
        logic bin_trivial;
        logic bin_range;
        logic list_open;
        logic new_range;
        logic range_flag;
        logic need_build;
        logic bld_more;
        logic mul_last;
        logic out_free;
    } dp_stat_t;

    // Start address of row r in the triangle store: r(r+1)/2.
    function automatic logic [ADDR_W-1:0] row_base(input logic [FIELD_W-1:0] r);
        logic [2*FIELD_W-1:0] p;
        p = (2 * FIELD_W)'(r) * ((2 * FIELD_W)'(r) + (2 * FIELD_W)'(1));
        return p[ADDR_W:1];
    endfunction

endpackage

// File: rtl/core/mce_ctrl.sv
// Controller state machine that sequences row building, table reads and multiplies.
module mce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  mce_pkg::dp_stat_t stat,
    output mce_pkg::dp_cmd_t  cmd
);

    mce_pkg::state_t state_reg;
    mce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mce_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            mce_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mce_pkg::ST_DECIDE;
                end
            end
            mce_pkg::ST_DECIDE:
            begin
                if (!stat.op_multi)
                begin
                    if (stat.bin_trivial || stat.bin_range)
                    begin
                        cmd.bin_fixed = 1'b1;
                        state_next    = mce_pkg::ST_EMIT;
                    end
                    else
                    begin
                        cmd.set_nk_bin = 1'b1;
                        state_next     = mce_pkg::ST_BCHK;
                    end
                end
                else if (!stat.list_open)
                begin
                    cmd.list_first = 1'b1;
                    state_next     = stat.last ? mce_pkg::ST_EMIT : mce_pkg::ST_IDLE;
                end
                else if (stat.new_range)
                begin
                    cmd.list_range = 1'b1;
                    state_next     = stat.last ? mce_pkg::ST_EMIT : mce_pkg::ST_IDLE;
                end
                else if (stat.range_flag)
                begin
                    cmd.list_skip = 1'b1;
                    state_next    = stat.last ? mce_pkg::ST_EMIT : mce_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.set_nk_list = 1'b1;
                    state_next      = mce_pkg::ST_BCHK;
                end
            end
            mce_pkg::ST_BCHK:
            begin
                if (stat.need_build)
                begin
                    cmd.row_init = 1'b1;
                    state_next   = mce_pkg::ST_BHEAD;
                end
                else
                begin
                    state_next = mce_pkg::ST_READ;
                end
            end
            mce_pkg::ST_BHEAD:
            begin
                cmd.row_head = 1'b1;
                state_next   = mce_pkg::ST_BNEXT;
            end
            mce_pkg::ST_BNEXT:
            begin
                state_next = stat.bld_more ? mce_pkg::ST_BRD : mce_pkg::ST_BTAIL;
            end
            mce_pkg::ST_BRD:
            begin
                cmd.row_rd = 1'b1;
                state_next = mce_pkg::ST_BWR;
            end
            mce_pkg::ST_BWR:
            begin
                cmd.row_wr = 1'b1;
                state_next = mce_pkg::ST_BNEXT;
            end
            mce_pkg::ST_BTAIL:
            begin
                cmd.row_tail = 1'b1;
                state_next   = mce_pkg::ST_BCHK;
            end
            mce_pkg::ST_READ:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = mce_pkg::ST_RWAIT;
            end
            mce_pkg::ST_RWAIT:
            begin
                if (stat.op_multi)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = mce_pkg::ST_MUL;
                end
                else
                begin
                    cmd.bin_capture = 1'b1;
                    state_next      = mce_pkg::ST_EMIT;
                end
            end
            mce_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                begin
                    state_next = mce_pkg::ST_MDONE;
                end
            end
            mce_pkg::ST_MDONE:
            begin
                cmd.mul_done = 1'b1;
                state_next   = stat.last ? mce_pkg::ST_EMIT : mce_pkg::ST_IDLE;
            end
            mce_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mce_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == mce_pkg::ST_IDLE);

endmodule

// File: rtl/core/mce_dp.sv
// Datapath: triangle store, row builder, list state, shared multiplier and output register.
module mce_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [mce_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mce_pkg::COEF_W-1:0]        m_tdata,
    output logic [mce_pkg::OUT_USER_W-1:0]    m_tuser,
    input  mce_pkg::dp_cmd_t                  cmd,
    output mce_pkg::dp_stat_t                 stat
);

    localparam int FW = mce_pkg::FIELD_W;
    localparam int SW = mce_pkg::SUM_W;
    localparam int CW = mce_pkg::COEF_W;
    localparam int HW = mce_pkg::HALF_W;
    localparam int AW = mce_pkg::ADDR_W;
    localparam int QW = mce_pkg::ACC_W;

    // Triangle store and its registered read port.
    logic [CW-1:0] mem [mce_pkg::STORE_DEPTH];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [CW-1:0] mem_wdata;

    // Latched input item.
    logic          op_reg, op_next;
    logic          last_reg, last_next;
    logic [FW-1:0] upper_reg, upper_next;
    logic [FW-1:0] lower_reg, lower_next;
    logic [FW-1:0] part_reg, part_next;

    // Query row and entry, row builder cursor.
    logic [FW-1:0] n_reg, n_next;
    logic [FW-1:0] k_reg, k_next;
    logic [AW-1:0] base_reg, base_next;
    logic [FW-1:0] i_reg, i_next;
    logic [CW-1:0] left_reg, left_next;

    // Binomial result held until it is emitted.
    logic [CW-1:0] bin_reg, bin_next;
    logic          bin_rng_reg, bin_rng_next;

    // Multiplier operand and accumulator.
    logic [CW-1:0] mulb_reg, mulb_next;
    logic [QW-1:0] acc_reg, acc_next;

    // Control state; all but the output coefficient and flags have reset values.
    logic [FW-1:0] rows_ready_reg, rows_ready_next;
    logic [SW-1:0] sum_reg, sum_next;
    logic [CW-1:0] prod_reg, prod_next;
    logic          open_reg, open_next;
    logic          ovf_reg, ovf_next;
    logic          rng_reg, rng_next;
    logic [1:0]    mcnt_reg, mcnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] out_coef_reg, out_coef_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_rng_reg, out_rng_next;

    logic [SW:0]   sum_wide;
    logic [SW-1:0] new_sum;
    logic [HW-1:0] a_half;
    logic [HW-1:0] b_half;
    logic [CW-1:0] pp;
    logic [QW-1:0] pp_shift;
    logic [1:0]    shift_sel;
    logic          prod_hi;

    assign sum_wide = {1'b0, sum_reg} + (SW + 1)'(part_reg);
    assign new_sum  = (sum_wide > (SW + 1)'(mce_pkg::SUM_CAP)) ? mce_pkg::SUM_CAP
                                                                : sum_wide[SW-1:0];

    // One 32x32 partial product per step, placed at its weight in the accumulator.
    assign a_half    = mcnt_reg[0] ? prod_reg[CW-1:HW] : prod_reg[HW-1:0];
    assign b_half    = mcnt_reg[1] ? mulb_reg[CW-1:HW] : mulb_reg[HW-1:0];
    assign pp        = CW'(a_half) * CW'(b_half);
    assign shift_sel = {1'b0, mcnt_reg[0]} + {1'b0, mcnt_reg[1]};
    assign prod_hi   = (acc_reg[QW-1:CW] != '0);

    always_comb
    begin
        case (shift_sel)
            2'd0:    pp_shift = {{(QW - CW){1'b0}}, pp};
            2'd1:    pp_shift = {{(QW - CW - HW){1'b0}}, pp, {HW{1'b0}}};
            2'd2:    pp_shift = {pp, {(QW - CW){1'b0}}};
            default: pp_shift = '0;
        endcase
    end

    // Store access.
    assign mem_we    = cmd.row_head | cmd.row_wr | cmd.row_tail;
    assign mem_re    = cmd.row_rd | cmd.tbl_rd;
    assign mem_waddr = cmd.row_tail ? base_reg + AW'(rows_ready_reg) : base_reg + AW'(i_reg);
    assign mem_wdata = cmd.row_wr ? left_reg + rd_data_reg : CW'(1);
    assign mem_raddr = cmd.tbl_rd ? mce_pkg::row_base(n_reg) + AW'(k_reg)
                                  : base_reg - AW'(rows_ready_reg) + AW'(i_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        op_next         = op_reg;
        last_next       = last_reg;
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        part_next       = part_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        i_next          = i_reg;
        left_next       = left_reg;
        bin_next        = bin_reg;
        bin_rng_next    = bin_rng_reg;
        mulb_next       = mulb_reg;
        acc_next        = acc_reg;
        rows_ready_next = rows_ready_reg;
        sum_next        = sum_reg;
        prod_next       = prod_reg;
        open_next       = open_reg;
        ovf_next        = ovf_reg;
        rng_next        = rng_reg;
        mcnt_next       = mcnt_reg;
        out_valid_next  = out_valid_reg;
        out_coef_next   = out_coef_reg;
        out_ovf_next    = out_ovf_reg;
        out_rng_next    = out_rng_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.load)
        begin
            op_next    = s_tuser;
            last_next  = s_tlast;
            upper_next = s_tdata[FW-1:0];
            lower_next = s_tdata[2*FW-1:FW];
            part_next  = s_tdata[3*FW-1:2*FW];
        end
        if (cmd.bin_fixed)
        begin
            bin_next     = '0;
            bin_rng_next = !(lower_reg > upper_reg);
        end
        if (cmd.set_nk_bin)
        begin
            n_next = upper_reg;
            k_next = lower_reg;
        end
        if (cmd.list_first)
        begin
            open_next = 1'b1;
            sum_next  = SW'(part_reg);
            prod_next = CW'(1);
            ovf_next  = 1'b0;
            rng_next  = 1'b0;
        end
        if (cmd.list_range)
        begin
            rng_next  = 1'b1;
            prod_next = '0;
            sum_next  = new_sum;
        end
        if (cmd.list_skip)
        begin
            sum_next = new_sum;
        end
        if (cmd.set_nk_list)
        begin
            n_next = FW'(new_sum);
            k_next = FW'(sum_reg);
        end
        if (cmd.row_init)
        begin
            base_next = mce_pkg::row_base(rows_ready_reg);
            i_next    = '0;
        end
        if (cmd.row_head)
        begin
            left_next = CW'(1);
            i_next    = i_reg + FW'(1);
        end
        if (cmd.row_wr)
        begin
            left_next = rd_data_reg;
            i_next    = i_reg + FW'(1);
        end
        if (cmd.row_tail)
        begin
            rows_ready_next = rows_ready_reg + FW'(1);
        end
        if (cmd.bin_capture)
        begin
            bin_next     = rd_data_reg;
            bin_rng_next = 1'b0;
        end
        if (cmd.mul_start)
        begin
            mulb_next = rd_data_reg;
            acc_next  = '0;
            mcnt_next = '0;
        end
        if (cmd.mul_step)
        begin
            acc_next  = acc_reg + pp_shift;
            mcnt_next = mcnt_reg + 2'd1;
        end
        if (cmd.mul_done)
        begin
            prod_next = prod_hi ? '1 : acc_reg[CW-1:0];
            ovf_next  = ovf_reg | prod_hi;
            sum_next  = SW'(n_reg);
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (op_reg == mce_pkg::OP_BINOMIAL)
            begin
                out_coef_next = bin_reg;
                out_ovf_next  = 1'b0;
                out_rng_next  = bin_rng_reg;
            end
            else
            begin
                out_coef_next = rng_reg ? '0 : prod_reg;
                out_ovf_next  = ovf_reg;
                out_rng_next  = rng_reg;
                open_next     = 1'b0;
                sum_next      = '0;
                prod_next     = CW'(1);
                ovf_next      = 1'b0;
                rng_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_ready_reg <= '0;
            sum_reg        <= '0;
            prod_reg       <= CW'(1);
            open_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
            rng_reg        <= 1'b0;
            mcnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rows_ready_reg <= rows_ready_next;
            sum_reg        <= sum_next;
            prod_reg       <= prod_next;
            open_reg       <= open_next;
            ovf_reg        <= ovf_next;
            rng_reg        <= rng_next;
            mcnt_reg       <= mcnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        upper_reg    <= upper_next;
        lower_reg    <= lower_next;
        part_reg     <= part_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        base_reg     <= base_next;
        i_reg        <= i_next;
        left_reg     <= left_next;
        bin_reg      <= bin_next;
        bin_rng_reg  <= bin_rng_next;
        mulb_reg     <= mulb_next;
        acc_reg      <= acc_next;
        out_coef_reg <= out_coef_next;
        out_ovf_reg  <= out_ovf_next;
        out_rng_reg  <= out_rng_next;
    end

    assign stat.op_multi    = (op_reg == mce_pkg::OP_MULTINOMIAL);
    assign stat.last        = last_reg;
    assign stat.bin_trivial = (lower_reg > upper_reg);
    assign stat.bin_range   = (upper_reg > FW'(mce_pkg::MAX_ROW));
    assign stat.list_open   = open_reg;
    assign stat.new_range   = (new_sum > SW'(mce_pkg::MAX_ROW));
    assign stat.range_flag  = rng_reg;
    assign stat.need_build  = (rows_ready_reg <= n_reg);
    assign stat.bld_more    = (i_reg < rows_ready_reg);
    assign stat.mul_last    = (mcnt_reg == '1);
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_coef_reg;
    assign m_tuser  = {out_rng_reg, out_ovf_reg};

endmodule

// File: rtl/core/multinomial_coefficient_engine.sv
// Top level of the multinomial coefficient engine: controller plus datapath.
//
// This block answers binomial queries C(upper, lower) and multinomial
// coefficients from a Pascal triangle kept in a 2080-entry by 64-bit store
// (rows 0 through MAX_ROW). Rows are built on demand, up to the highest row
// a query needs, and stay built until reset; the store needs no clearing
// pass because an entry is only read after its row was written. The block
// works on one item at a time, and s_tready is high only while it waits
// for the next transfer. A binomial query from rows that are already built
// goes through a table read and its capture; a query with lower above
// upper or a row beyond MAX_ROW is answered directly, and the first part
// of a list only opens it. A later part in range reads the table, then makes
// four passes through one shared 32x32 multiplier. A transfer that ends a
// list or answers a query then waits in the emit state until the output
// register is free and loads it. Building a missing row r writes its head,
// one table read and one write for each inner entry, and its tail. The
// output register lets the next input transfer be accepted while a result
// still waits, and the block only stalls when a new result is ready before
// the old one is taken. Multinomial products saturate at all ones and raise
// the overflow flag; a running sum beyond MAX_ROW raises range_error and
// forces the coefficient to zero. Both flags stay set until the list ends.
module multinomial_coefficient_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: upper[6:0], lower[13:7], part[20:14], zero fill.
    input  logic [mce_pkg::IN_DATA_W-1:0]     s_tdata,
    // s_tuser: opcode (0 binomial query, 1 multinomial part).
    input  logic                              s_tuser,
    // s_tlast: last_part, the final part of a multinomial list.
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: coefficient[63:0].
    output logic [mce_pkg::COEF_W-1:0]        m_tdata,
    // m_tuser from bit 0: overflow, range_error.
    output logic [mce_pkg::OUT_USER_W-1:0]    m_tuser
);

    mce_pkg::dp_cmd_t  cmd;
    mce_pkg::dp_stat_t stat;

    // The controller sequences every step; the datapath only follows commands.
    mce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the store, the list state and the output register.
    mce_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: rtl/core/mce_checker.sv
// Port-level checker for the multinomial coefficient engine and its bind.
`include "assert_macros.svh"

module mce_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [mce_pkg::COEF_W-1:0]        m_tdata,
    input logic [mce_pkg::OUT_USER_W-1:0]    m_tuser
);

    // A result that is not taken stays offered.
    `MCE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A range error always comes with a zero coefficient.
    `MCE_ASSERT_SAME(a_range_zero, m_tvalid && m_tuser[1], m_tdata == '0, "range error with nonzero coefficient")

    // An overflow without a range error carries the saturated value.
    `MCE_ASSERT_SAME(a_ovf_sat, m_tvalid && m_tuser[0] && !m_tuser[1], &m_tdata, "overflow without saturation")

    // After an input transfer the block is busy in the following cycle.
    `MCE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready right after a transfer")

endmodule

bind multinomial_coefficient_engine mce_checker u_mce_checker (.*);
